// ===== rtl/plh_pkg.sv =====
// Shared constants, codes and types for the pixel histogram.
package plh_pkg;

  localparam int BINS_PER_BANK = 256;
  localparam int BIN_W         = $clog2(BINS_PER_BANK);
  localparam int NUM_BANKS     = 3;
  localparam int BANK_W        = 2;
  localparam int COUNT_WIDTH   = 32;
  localparam int OUT_W         = 32;
  localparam int PIX_W         = 8;
  localparam int INDEX_W       = BIN_W + BANK_W;

  // luma = (306 r + 601 g + 117 b) >> 10
  localparam int LUMA_R     = 306;
  localparam int LUMA_G     = 601;
  localparam int LUMA_B     = 117;
  localparam int LUMA_SHIFT = 10;
  localparam int LUMA_SUM_W = PIX_W + LUMA_SHIFT;

  localparam logic [1:0] ACT_ADD        = 2'd0;
  localparam logic [1:0] ACT_READ       = 2'd1;
  localparam logic [1:0] ACT_READ_CLEAR = 2'd2;
  localparam logic [1:0] ACT_CLEAR_PIX  = 2'd3;

  localparam logic [1:0] MODE_LUMA     = 2'd0;
  localparam logic [1:0] MODE_LUMA_SAT = 2'd1;
  localparam logic [1:0] MODE_RGB      = 2'd2;

  // Decoded request: which bank entries to touch and what to do with them.
  typedef struct packed {
    logic [NUM_BANKS-1:0]            inc;
    logic [NUM_BANKS-1:0][BIN_W-1:0] addr;
    logic                            count_pix;
    logic                            rd;
    logic                            clr;
    logic                            clr_pix;
    logic [BANK_W-1:0]               bank;
  } bank_req_t;

endpackage

// ===== rtl/plh_if.sv =====
// Request channels: pixel/action requests in, bin readout results out.
interface plh_pix_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [plh_pkg::PIX_W-1:0]   red;
  logic [plh_pkg::PIX_W-1:0]   green;
  logic [plh_pkg::PIX_W-1:0]   blue;
  logic [plh_pkg::INDEX_W-1:0] bin_index;

  modport source (output valid, action, red, green, blue, bin_index, input ready);
  modport sink   (input valid, action, red, green, blue, bin_index, output ready);
endinterface

interface plh_res_if;
  logic                      valid;
  logic                      ready;
  logic [plh_pkg::OUT_W-1:0] bin_count;
  logic [plh_pkg::OUT_W-1:0] pixels_seen;

  modport source (output valid, bin_count, pixels_seen, input ready);
  modport sink   (input valid, bin_count, pixels_seen, output ready);
endinterface

// ===== rtl/pixel_luma_channel_histogram.sv =====
// Histogram of RGB pixels over three banks of 256 saturating bins. Every request
// (add pixel, read bin, read-and-clear bin, clear pixel count) is handled in the
// IDLE and UPDATE states: the bank memories are read on acceptance and written
// back in UPDATE, so no new request is taken before the last one leaves UPDATE.
// A read waits in the result register without blocking the next request, unless
// a second read finds it still occupied. After reset a clearing pass zeroes all
// three banks in parallel, one bin per cycle, from bin 0 to bin 255; no request is
// accepted until it finishes, while hist_mode writes are taken at any time.
module pixel_luma_channel_histogram #(
  parameter int COUNT_WIDTH = plh_pkg::COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  plh_pix_if.sink          pixel,
  plh_res_if.source        result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [plh_pkg::BIN_W-1:0]    clr_addr;
  logic [1:0]                   hist_mode;
  logic [COUNT_WIDTH-1:0]       pix_cnt;
  plh_pkg::bank_req_t           req;
  plh_pkg::bank_req_t           req_q;
  logic [COUNT_WIDTH-1:0]       rd_data [plh_pkg::NUM_BANKS];
  logic [COUNT_WIDTH-1:0]       sel_count;
  logic [plh_pkg::OUT_W-1:0]    sel_clip;
  logic [plh_pkg::OUT_W-1:0]    pix_clip;
  logic                         accept;
  logic                         upd_go;
  logic                         out_valid;
  logic [plh_pkg::OUT_W-1:0]    bin_count;
  logic [plh_pkg::OUT_W-1:0]    pixels_seen;

  plh_map u_map (
    .hist_mode (hist_mode),
    .action    (pixel.action),
    .red       (pixel.red),
    .green     (pixel.green),
    .blue      (pixel.blue),
    .bin_index (pixel.bin_index),
    .req       (req)
  );

  assign pixel.ready = (state == ST_IDLE);
  assign accept      = pixel.valid && pixel.ready;
  // a read holds in UPDATE while the previous result is still unclaimed
  assign upd_go      = (state == ST_UPDATE) &&
                       !(req_q.rd && out_valid && !result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (&clr_addr) state_next = ST_IDLE;
      ST_IDLE:   if (accept)    state_next = ST_UPDATE;
      ST_UPDATE: if (upd_go)    state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_mode <= plh_pkg::MODE_LUMA;
    end else if (cfg_we) begin
      hist_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
  end

  // bank memories: read on accept, read-modify-write in UPDATE
  for (genvar k = 0; k < plh_pkg::NUM_BANKS; k++) begin : g_bank
    logic [COUNT_WIDTH-1:0] mem [plh_pkg::BINS_PER_BANK];
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign wr_en   = upd_go && (req_q.inc[k] ||
                     (req_q.clr && (req_q.bank == plh_pkg::BANK_W'(k))));
    assign wr_data = req_q.clr ? '0 :
                     ((&rd_data[k]) ? rd_data[k] : rd_data[k] + 1'b1);

    always_ff @(posedge clk) begin
      if (state == ST_CLEAR) begin
        mem[clr_addr] <= '0;
      end else if (wr_en) begin
        mem[req_q.addr[k]] <= wr_data;
      end
      if (accept) rd_data[k] <= mem[req.addr[k]];
    end
  end

  always_comb begin
    sel_count = '0;
    for (int k = 0; k < plh_pkg::NUM_BANKS; k++) begin
      if (req_q.bank == plh_pkg::BANK_W'(k)) sel_count = rd_data[k];
    end
  end

  if (COUNT_WIDTH > plh_pkg::OUT_W) begin : g_clip
    assign sel_clip = (|sel_count[COUNT_WIDTH-1:plh_pkg::OUT_W]) ? '1 :
                      sel_count[plh_pkg::OUT_W-1:0];
    assign pix_clip = (|pix_cnt[COUNT_WIDTH-1:plh_pkg::OUT_W]) ? '1 :
                      pix_cnt[plh_pkg::OUT_W-1:0];
  end else begin : g_ext
    assign sel_clip = plh_pkg::OUT_W'(sel_count);
    assign pix_clip = plh_pkg::OUT_W'(pix_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
    end else if (upd_go) begin
      if (req_q.clr_pix) begin
        pix_cnt <= '0;
      end else if (req_q.count_pix && !(&pix_cnt)) begin
        pix_cnt <= pix_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go && req_q.rd) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && req_q.rd) begin
      bin_count   <= sel_clip;
      pixels_seen <= pix_clip;
    end
  end

  assign result.valid       = out_valid;
  assign result.bin_count   = bin_count;
  assign result.pixels_seen = pixels_seen;

endmodule

// ===== rtl/plh_map.sv =====
// Decodes one request into per-bank bin addresses (luma, saturation, rgb).
module plh_map (
  input  logic [1:0]                   hist_mode,
  input  logic [1:0]                   action,
  input  logic [plh_pkg::PIX_W-1:0]    red,
  input  logic [plh_pkg::PIX_W-1:0]    green,
  input  logic [plh_pkg::PIX_W-1:0]    blue,
  input  logic [plh_pkg::INDEX_W-1:0]  bin_index,
  output plh_pkg::bank_req_t           req
);

  logic [plh_pkg::LUMA_SUM_W-1:0] luma_sum;
  logic [plh_pkg::PIX_W-1:0]      luma;
  logic [plh_pkg::PIX_W-1:0]      d_rg;
  logic [plh_pkg::PIX_W-1:0]      d_gb;
  logic [plh_pkg::PIX_W-1:0]      sat;

  assign luma_sum = plh_pkg::LUMA_SUM_W'(plh_pkg::LUMA_R * 32'(red)
                                       + plh_pkg::LUMA_G * 32'(green)
                                       + plh_pkg::LUMA_B * 32'(blue));
  assign luma = plh_pkg::PIX_W'(luma_sum >> plh_pkg::LUMA_SHIFT);
  assign d_rg = (red > green) ? red - green : green - red;
  assign d_gb = (green > blue) ? green - blue : blue - green;
  // max of two 8-bit differences never exceeds 255, no clamp needed
  assign sat  = (d_rg > d_gb) ? d_rg : d_gb;

  always_comb begin
    req      = '0;
    req.bank = bin_index[plh_pkg::BIN_W +: plh_pkg::BANK_W];
    unique case (action)
      plh_pkg::ACT_ADD: begin
        unique case (hist_mode)
          plh_pkg::MODE_LUMA: begin
            req.inc       = 3'b001;
            req.addr[0]   = luma;
            req.count_pix = 1'b1;
          end
          plh_pkg::MODE_LUMA_SAT: begin
            req.inc       = 3'b011;
            req.addr[0]   = luma;
            req.addr[1]   = sat;
            req.count_pix = 1'b1;
          end
          plh_pkg::MODE_RGB: begin
            req.inc       = 3'b111;
            req.addr[0]   = red;
            req.addr[1]   = green;
            req.addr[2]   = blue;
            req.count_pix = 1'b1;
          end
          default: begin
            // unused mode: pixel ignored
            req.inc = '0;
          end
        endcase
      end
      plh_pkg::ACT_READ: begin
        req.rd = 1'b1;
        for (int k = 0; k < plh_pkg::NUM_BANKS; k++) begin
          req.addr[k] = bin_index[plh_pkg::BIN_W-1:0];
        end
      end
      plh_pkg::ACT_READ_CLEAR: begin
        req.rd  = 1'b1;
        req.clr = 1'b1;
        for (int k = 0; k < plh_pkg::NUM_BANKS; k++) begin
          req.addr[k] = bin_index[plh_pkg::BIN_W-1:0];
        end
      end
      plh_pkg::ACT_CLEAR_PIX: begin
        req.clr_pix = 1'b1;
      end
    endcase
  end

endmodule
